// ===== hw/rtl/apdmg_pkg.sv =====
// ----------------------------------------------------------------------------
// apdmg_pkg
// shared types and constants of the absolute peak detector with minimum gap
// ----------------------------------------------------------------------------
package apdmg_pkg;

    // default widths and sizes
    localparam int ANGLE_WIDTH_DEF = 24;
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 20;
    localparam int QUEUE_DEPTH_DEF = 4;

    // reset values of the configuration registers
    localparam logic REG_GAP_MODE_RST     = 1'b0;
    localparam int   MIN_INDEX_GAP_RST    = 1;
    localparam int   MIN_TIME_GAP_RST     = 0;
    localparam int   MIN_PEAK_COUNT_RST   = 4;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP_MODE       = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_INDEX_GAP  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_TIME_GAP   = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_PEAK_COUNT = 2'd3;

    // gap modes
    localparam logic GAP_MODE_COUNT = 1'b0;
    localparam logic GAP_MODE_TIME  = 1'b1;

    // result kinds
    localparam logic KIND_PEAK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // end-of-record status codes
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_FEW_SAMPLES = 2'd1,
        STATUS_FEW_PEAKS   = 2'd2
    } status_t;

    // control part of one queue entry
    typedef struct packed {
        logic    has_peak;
        logic    has_summary;
        status_t status;
    } entry_ctrl_t;

endpackage

// ===== hw/rtl/apdmg_queue.sv =====
// ----------------------------------------------------------------------------
// apdmg_queue
// small register fifo between the detection front and the result back
// ----------------------------------------------------------------------------
module apdmg_queue
    import apdmg_pkg::*;
#(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] head_data,
    output logic                  empty,
    output logic                  full
);

    localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_WIDTH-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0]  count_reg, count_next;
    logic                  do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_WIDTH'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign head_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/apdmg_front.sv =====
// ----------------------------------------------------------------------------
// apdmg_front
// takes samples, tracks the three-sample window and the gap to the last
// accepted peak, and queues peak and summary work
// ----------------------------------------------------------------------------
module apdmg_front
    import apdmg_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    input  logic                          queue_full,
    input  logic [TIME_WIDTH-1:0]         sample_time,
    input  logic signed [ANGLE_WIDTH-1:0] sample_angle,
    input  logic                          last_sample,
    input  logic                          gap_mode,
    input  logic [COUNT_WIDTH-1:0]        min_index_gap,
    input  logic [TIME_WIDTH-1:0]         min_time_gap,
    input  logic [COUNT_WIDTH-1:0]        min_peak_count,
    output logic                          sample_stall,
    output logic                          push,
    output entry_ctrl_t                   push_ctrl,
    output logic [TIME_WIDTH-1:0]         push_time,
    output logic [ANGLE_WIDTH-2:0]        push_mag,
    output logic [COUNT_WIDTH-1:0]        push_count
);

    localparam int MAG_WIDTH = ANGLE_WIDTH - 1;

    logic [MAG_WIDTH-1:0]   older_mag_reg;
    logic [MAG_WIDTH-1:0]   middle_mag_reg;
    logic [TIME_WIDTH-1:0]  middle_time_reg;
    logic [COUNT_WIDTH-1:0] sample_counter_reg;
    logic [COUNT_WIDTH-1:0] accepted_index_reg;
    logic [TIME_WIDTH-1:0]  accepted_time_reg;
    logic                   have_accepted_reg;
    logic [COUNT_WIDTH-1:0] peaks_found_reg;

    logic                   accept;
    logic [ANGLE_WIDTH-1:0] negated;
    logic [MAG_WIDTH-1:0]   mag_now;
    logic [COUNT_WIDTH-1:0] mid_index;
    logic [COUNT_WIDTH-1:0] index_dist;
    logic [TIME_WIDTH-1:0]  time_dist;
    logic                   is_peak;
    logic                   far_enough;
    logic                   take_peak;
    logic [COUNT_WIDTH-1:0] peaks_found_next;
    status_t                end_status;

    assign sample_stall = queue_full;
    assign accept       = sample_valid && !sample_stall;

    // magnitude, most negative angle saturates
    assign negated = ~sample_angle + 1'b1;
    always_comb
    begin
        if (!sample_angle[ANGLE_WIDTH-1])
        begin
            mag_now = sample_angle[MAG_WIDTH-1:0];
        end
        else if (negated[ANGLE_WIDTH-1])
        begin
            mag_now = '1;
        end
        else
        begin
            mag_now = negated[MAG_WIDTH-1:0];
        end
    end

    assign mid_index  = sample_counter_reg - COUNT_WIDTH'(1);
    assign index_dist = (mid_index >= accepted_index_reg)
                        ? mid_index - accepted_index_reg : '0;
    assign time_dist  = (middle_time_reg >= accepted_time_reg)
                        ? middle_time_reg - accepted_time_reg : '0;

    assign is_peak = (sample_counter_reg > COUNT_WIDTH'(1))
                     && (middle_mag_reg >= older_mag_reg)
                     && (middle_mag_reg > mag_now);

    assign far_enough = !have_accepted_reg
                        || ((gap_mode == GAP_MODE_TIME) ? (time_dist >= min_time_gap)
                                                        : (index_dist >= min_index_gap));
    assign take_peak  = is_peak && far_enough;

    assign peaks_found_next = (take_peak && (peaks_found_reg != '1))
                              ? peaks_found_reg + 1'b1 : peaks_found_reg;

    always_comb
    begin
        if (sample_counter_reg < COUNT_WIDTH'(2))
        begin
            end_status = STATUS_FEW_SAMPLES;
        end
        else if (peaks_found_next < min_peak_count)
        begin
            end_status = STATUS_FEW_PEAKS;
        end
        else
        begin
            end_status = STATUS_OK;
        end
    end

    assign push                  = accept && (take_peak || last_sample);
    assign push_ctrl.has_peak    = take_peak;
    assign push_ctrl.has_summary = last_sample;
    assign push_ctrl.status      = end_status;
    assign push_time             = middle_time_reg;
    assign push_mag              = middle_mag_reg;
    assign push_count            = peaks_found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_mag_reg      <= '0;
            middle_mag_reg     <= '0;
            middle_time_reg    <= '0;
            sample_counter_reg <= '0;
            accepted_index_reg <= '0;
            accepted_time_reg  <= '0;
            have_accepted_reg  <= 1'b0;
            peaks_found_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_sample)
            begin
                older_mag_reg      <= '0;
                middle_mag_reg     <= '0;
                middle_time_reg    <= '0;
                sample_counter_reg <= '0;
                accepted_index_reg <= '0;
                accepted_time_reg  <= '0;
                have_accepted_reg  <= 1'b0;
                peaks_found_reg    <= '0;
            end
            else
            begin
                if (take_peak)
                begin
                    have_accepted_reg  <= 1'b1;
                    accepted_index_reg <= mid_index;
                    accepted_time_reg  <= middle_time_reg;
                end
                peaks_found_reg <= peaks_found_next;
                older_mag_reg   <= middle_mag_reg;
                middle_mag_reg  <= mag_now;
                middle_time_reg <= sample_time;
                if (sample_counter_reg != '1)
                begin
                    sample_counter_reg <= sample_counter_reg + 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/apdmg_back.sv =====
// ----------------------------------------------------------------------------
// apdmg_back
// turns queued entries into peak reports and summaries in an output register
// ----------------------------------------------------------------------------
module apdmg_back
    import apdmg_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  entry_ctrl_t            head_ctrl,
    input  logic [TIME_WIDTH-1:0]  head_time,
    input  logic [ANGLE_WIDTH-2:0] head_mag,
    input  logic [COUNT_WIDTH-1:0] head_count,
    input  logic                   result_stall,
    output logic                   pop,
    output logic                   result_valid,
    output logic                   kind,
    output logic [TIME_WIDTH-1:0]  peak_time,
    output logic [ANGLE_WIDTH-2:0] peak_magnitude,
    output logic [COUNT_WIDTH-1:0] peak_count,
    output logic [1:0]             status,
    output logic                   last
);

    logic                   valid_reg, valid_next;
    logic                   phase_reg, phase_next;
    logic                   kind_reg;
    logic [TIME_WIDTH-1:0]  time_reg;
    logic [ANGLE_WIDTH-2:0] mag_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [1:0]             status_reg;
    logic                   last_reg;

    logic                   load;
    logic                   emit_peak;

    // output slot is free when empty or being taken
    assign load      = head_valid && (!valid_reg || !result_stall);
    assign emit_peak = head_ctrl.has_peak && !phase_reg;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        if (!valid_reg || !result_stall)
        begin
            valid_next = head_valid;
        end
        if (load)
        begin
            if (emit_peak && head_ctrl.has_summary)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            count_reg <= head_count;
            if (emit_peak)
            begin
                kind_reg   <= KIND_PEAK;
                time_reg   <= head_time;
                mag_reg    <= head_mag;
                status_reg <= STATUS_OK;
                last_reg   <= !head_ctrl.has_summary;
            end
            else
            begin
                kind_reg   <= KIND_SUMMARY;
                time_reg   <= '0;
                mag_reg    <= '0;
                status_reg <= head_ctrl.status;
                last_reg   <= 1'b1;
            end
        end
    end

    assign result_valid   = valid_reg;
    assign kind           = kind_reg;
    assign peak_time      = time_reg;
    assign peak_magnitude = mag_reg;
    assign peak_count     = count_reg;
    assign status         = status_reg;
    assign last           = last_reg;

endmodule

// ===== hw/rtl/abs_peak_detector_min_gap.sv =====
// ----------------------------------------------------------------------------
// abs_peak_detector_min_gap
// local maxima of |angle| on a timed sample stream, with a minimum gap
// between accepted peaks counted in samples or in microseconds
// ----------------------------------------------------------------------------
// path: a peak report or summary enters the entry queue when its sample is
//   taken, then the output register; a summary behind a peak follows it
// throughput: one sample per cycle unless stalled; a final sample that also
//   closes a peak gives two results, absorbed by the queue between the halves
// reset: rst_n clears record state, queue and output register, and loads
//   gap_mode 0, min_index_gap 1, min_time_gap 0, min_peak_count 4
module abs_peak_detector_min_gap
    import apdmg_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // sample channel
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [TIME_WIDTH-1:0]         sample_time,
    input  logic signed [ANGLE_WIDTH-1:0] sample_angle,
    input  logic                          last_sample,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          kind,
    output logic [TIME_WIDTH-1:0]         peak_time,
    output logic [ANGLE_WIDTH-2:0]        peak_magnitude,
    output logic [COUNT_WIDTH-1:0]        peak_count,
    output logic [1:0]                    status,
    output logic                          last,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [((TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH)-1:0] cfg_data
);

    localparam int MAG_WIDTH  = ANGLE_WIDTH - 1;
    localparam int CTRL_WIDTH = $bits(entry_ctrl_t);
    // queue entry layout: control, time, magnitude, count
    localparam int ENTRY_WIDTH = CTRL_WIDTH + TIME_WIDTH + MAG_WIDTH + COUNT_WIDTH;

    // configuration registers
    logic                   gap_mode_reg;
    logic [COUNT_WIDTH-1:0] min_index_gap_reg;
    logic [TIME_WIDTH-1:0]  min_time_gap_reg;
    logic [COUNT_WIDTH-1:0] min_peak_count_reg;

    // front to queue
    logic                   push;
    entry_ctrl_t            push_ctrl;
    logic [TIME_WIDTH-1:0]  push_time;
    logic [MAG_WIDTH-1:0]   push_mag;
    logic [COUNT_WIDTH-1:0] push_count;
    logic                   queue_full;

    // queue to back
    logic [ENTRY_WIDTH-1:0] head_data;
    logic                   queue_empty;
    logic                   pop;
    entry_ctrl_t            head_ctrl;
    logic [TIME_WIDTH-1:0]  head_time;
    logic [MAG_WIDTH-1:0]   head_mag;
    logic [COUNT_WIDTH-1:0] head_count;

    // the user writes the registers only while the block is idle; the block does not enforce it, so always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_mode_reg       <= REG_GAP_MODE_RST;
            min_index_gap_reg  <= COUNT_WIDTH'(MIN_INDEX_GAP_RST);
            min_time_gap_reg   <= TIME_WIDTH'(MIN_TIME_GAP_RST);
            min_peak_count_reg <= COUNT_WIDTH'(MIN_PEAK_COUNT_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAP_MODE:       gap_mode_reg       <= cfg_data[0];
                CFG_MIN_INDEX_GAP:  min_index_gap_reg  <= cfg_data[COUNT_WIDTH-1:0];
                CFG_MIN_TIME_GAP:   min_time_gap_reg   <= cfg_data[TIME_WIDTH-1:0];
                CFG_MIN_PEAK_COUNT: min_peak_count_reg <= cfg_data[COUNT_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    // front: window tracking, peak test, gap test and record summary
    apdmg_front #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .queue_full     (queue_full),
        .sample_time    (sample_time),
        .sample_angle   (sample_angle),
        .last_sample    (last_sample),
        .gap_mode       (gap_mode_reg),
        .min_index_gap  (min_index_gap_reg),
        .min_time_gap   (min_time_gap_reg),
        .min_peak_count (min_peak_count_reg),
        .sample_stall   (sample_stall),
        .push           (push),
        .push_ctrl      (push_ctrl),
        .push_time      (push_time),
        .push_mag       (push_mag),
        .push_count     (push_count)
    );

    // entry queue lets the back stall without holding the sample side until it fills
    apdmg_queue #(
        .DATA_WIDTH (ENTRY_WIDTH),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctrl, push_time, push_mag, push_count}),
        .pop       (pop),
        .head_data (head_data),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    assign {head_ctrl, head_time, head_mag, head_count} = head_data;

    // back: one or two result transactions per entry
    apdmg_back #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (!queue_empty),
        .head_ctrl      (head_ctrl),
        .head_time      (head_time),
        .head_mag       (head_mag),
        .head_count     (head_count),
        .result_stall   (result_stall),
        .pop            (pop),
        .result_valid   (result_valid),
        .kind           (kind),
        .peak_time      (peak_time),
        .peak_magnitude (peak_magnitude),
        .peak_count     (peak_count),
        .status         (status),
        .last           (last)
    );

endmodule

// ===== hw/rtl/apdmg_checker.sv =====
// ----------------------------------------------------------------------------
// apdmg_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
module apdmg_checker
    import apdmg_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  logic                   kind,
    input  logic [TIME_WIDTH-1:0]  peak_time,
    input  logic [ANGLE_WIDTH-2:0] peak_magnitude,
    input  logic [COUNT_WIDTH-1:0] peak_count,
    input  logic [1:0]             status,
    input  logic                   last
);

    // a stalled result transaction stays offered
    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result valid dropped while stalled");

    // a stalled result transaction keeps its payload
    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(kind) && $stable(peak_time)
            && $stable(peak_magnitude) && $stable(peak_count)
            && $stable(status) && $stable(last))
        else $error("result payload changed while stalled");

    // a summary always closes the results of its sample
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_SUMMARY) |-> last && (status != 2'd3))
        else $error("summary not last or bad status");

    // a peak report counts itself and carries no status
    a_peak_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_PEAK)
            |-> (peak_count != '0) && (status == STATUS_OK))
        else $error("peak report with zero count or nonzero status");

endmodule

bind abs_peak_detector_min_gap apdmg_checker #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
) u_apdmg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .peak_time      (peak_time),
    .peak_magnitude (peak_magnitude),
    .peak_count     (peak_count),
    .status         (status),
    .last           (last)
);

// ===== tb/abs_peak_detector_min_gap_checker.sv =====
// ----------------------------------------------------------------------------
// abs_peak_detector_min_gap_checker
// watches the sample, result and register channels of the peak detector,
// tracks the expected peak reports and record summaries, and compares every
// result transaction field by field against the oldest one still owed
// ----------------------------------------------------------------------------
module abs_peak_detector_min_gap_checker
    import apdmg_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    input  logic                              sample_stall,
    input  logic [TIME_WIDTH_DEF-1:0]         sample_time,
    input  logic signed [ANGLE_WIDTH_DEF-1:0] sample_angle,
    input  logic                              last_sample,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic                              kind,
    input  logic [TIME_WIDTH_DEF-1:0]         peak_time,
    input  logic [ANGLE_WIDTH_DEF-2:0]        peak_magnitude,
    input  logic [COUNT_WIDTH_DEF-1:0]        peak_count,
    input  logic [1:0]                        status,
    input  logic                              last,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [((TIME_WIDTH_DEF > COUNT_WIDTH_DEF) ? TIME_WIDTH_DEF : COUNT_WIDTH_DEF)-1:0]
                                              cfg_data,
    output int                                fail_count,
    output int                                outstanding,
    output int                                peak_reports,
    output int                                summaries
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = ANGLE_WIDTH_DEF;
    localparam int MW = ANGLE_WIDTH_DEF - 1;
    localparam int TW = TIME_WIDTH_DEF;
    localparam int CW = COUNT_WIDTH_DEF;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic          kind;
        logic [TW-1:0] stamp;
        logic [MW-1:0] magnitude;
        logic [CW-1:0] count;
        status_t       outcome;
        logic          last;
    } result_item_t;

    // register copies
    logic          gap_mode_q;
    logic [CW-1:0] min_index_gap_q;
    logic [TW-1:0] min_time_gap_q;
    logic [CW-1:0] min_peak_count_q;

    // record state
    logic [MW-1:0] older_mag;
    logic [MW-1:0] middle_mag;
    logic [TW-1:0] middle_stamp;
    logic [CW-1:0] samples_seen;
    logic [CW-1:0] last_peak_index;
    logic [TW-1:0] last_peak_stamp;
    logic          peak_taken;
    logic [CW-1:0] peaks_taken;

    result_item_t  owed_results[$];
    result_item_t  observed;
    int            mismatches;
    int            n_peaks;
    int            n_summaries;

    // |angle| with the most negative value saturated
    function automatic logic [MW-1:0] angle_magnitude(input logic signed [AW-1:0] a);
        logic [AW-1:0] negated;
        negated = ~a + 1'b1;
        if (!a[AW-1])
            return a[MW-1:0];
        if (negated[AW-1])
            return '1;
        return negated[MW-1:0];
    endfunction

    function automatic string describe(input result_item_t r);
        return $sformatf("kind %0d time %0d magnitude %0d count %0d status %0d last %0d",
                         r.kind, r.stamp, r.magnitude, r.count, r.outcome, r.last);
    endfunction

    task automatic clear_record();
        older_mag       = '0;
        middle_mag      = '0;
        middle_stamp    = '0;
        samples_seen    = '0;
        last_peak_index = '0;
        last_peak_stamp = '0;
        peak_taken      = 1'b0;
        peaks_taken     = '0;
    endtask

    // one sample moves the three-sample window and may close a peak
    task automatic advance_detector(input logic [TW-1:0] stamp,
                                    input logic signed [AW-1:0] angle,
                                    input logic final_one);
        logic [MW-1:0] mag_now;
        logic [CW-1:0] mid_index;
        logic [CW-1:0] index_dist;
        logic [TW-1:0] time_dist;
        logic          far_enough;
        result_item_t  r;
        mag_now = angle_magnitude(angle);
        if (samples_seen >= 2)
        begin
            mid_index = samples_seen - 1'b1;
            if (middle_mag >= older_mag && middle_mag > mag_now)
            begin
                if (!peak_taken)
                begin
                    far_enough = 1'b1;
                end
                else if (gap_mode_q == GAP_MODE_TIME)
                begin
                    time_dist  = (middle_stamp >= last_peak_stamp) ?
                                 middle_stamp - last_peak_stamp : '0;
                    far_enough = time_dist >= min_time_gap_q;
                end
                else
                begin
                    index_dist = (mid_index >= last_peak_index) ?
                                 mid_index - last_peak_index : '0;
                    far_enough = index_dist >= min_index_gap_q;
                end
                if (far_enough)
                begin
                    peak_taken      = 1'b1;
                    last_peak_index = mid_index;
                    last_peak_stamp = middle_stamp;
                    if (peaks_taken != '1)
                        peaks_taken = peaks_taken + 1'b1;
                    r.kind      = KIND_PEAK;
                    r.stamp     = middle_stamp;
                    r.magnitude = middle_mag;
                    r.count     = peaks_taken;
                    r.outcome   = STATUS_OK;
                    r.last      = !final_one;
                    owed_results = {owed_results, r};
                end
            end
        end
        if (final_one)
        begin
            r.kind      = KIND_SUMMARY;
            r.stamp     = '0;
            r.magnitude = '0;
            r.count     = peaks_taken;
            if (samples_seen < 2)
                r.outcome = STATUS_FEW_SAMPLES;
            else if (peaks_taken < min_peak_count_q)
                r.outcome = STATUS_FEW_PEAKS;
            else
                r.outcome = STATUS_OK;
            r.last      = 1'b1;
            owed_results = {owed_results, r};
            clear_record();
        end
        else
        begin
            older_mag    = middle_mag;
            middle_mag   = mag_now;
            middle_stamp = stamp;
            if (samples_seen != '1)
                samples_seen = samples_seen + 1'b1;
        end
    endtask

    task automatic check_result(input result_item_t got);
        result_item_t want;
        if (owed_results.size() == 0)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: unexpected result: %s", $time, describe(got));
            mismatches++;
        end
        else
        begin
            want = owed_results.pop_front();
            if (got.kind !== want.kind || got.stamp !== want.stamp ||
                got.magnitude !== want.magnitude || got.count !== want.count ||
                got.outcome !== want.outcome || got.last !== want.last)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                             $time, describe(want), describe(got));
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_mode_q       = REG_GAP_MODE_RST;
            min_index_gap_q  = CW'(MIN_INDEX_GAP_RST);
            min_time_gap_q   = TW'(MIN_TIME_GAP_RST);
            min_peak_count_q = CW'(MIN_PEAK_COUNT_RST);
            clear_record();
            owed_results.delete();
            mismatches  = 0;
            n_peaks     = 0;
            n_summaries = 0;
            fail_count   <= 0;
            outstanding  <= 0;
            peak_reports <= 0;
            summaries    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAP_MODE:       gap_mode_q       = cfg_data[0];
                    CFG_MIN_INDEX_GAP:  min_index_gap_q  = cfg_data[CW-1:0];
                    CFG_MIN_TIME_GAP:   min_time_gap_q   = cfg_data[TW-1:0];
                    CFG_MIN_PEAK_COUNT: min_peak_count_q = cfg_data[CW-1:0];
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
                advance_detector(sample_time, sample_angle, last_sample);
            if (result_valid && !result_stall)
            begin
                observed.kind      = kind;
                observed.stamp     = peak_time;
                observed.magnitude = peak_magnitude;
                observed.count     = peak_count;
                observed.outcome   = status_t'(status);
                observed.last      = last;
                check_result(observed);
                if (kind == KIND_SUMMARY)
                    n_summaries++;
                else
                    n_peaks++;
            end
            fail_count   <= mismatches;
            outstanding  <= owed_results.size();
            peak_reports <= n_peaks;
            summaries    <= n_summaries;
        end
    end

endmodule

// ===== tb/abs_peak_detector_min_gap_tb.sv =====
// ----------------------------------------------------------------------------
// abs_peak_detector_min_gap_tb
// drives timed angle records into the peak detector under several register
// settings, with bursty input and a stalling result side; the checker beside
// the block predicts every peak report and summary and counts mismatches
// ----------------------------------------------------------------------------
module abs_peak_detector_min_gap_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import apdmg_pkg::*;

    localparam int AW = ANGLE_WIDTH_DEF;
    localparam int TW = TIME_WIDTH_DEF;
    localparam int CW = COUNT_WIDTH_DEF;
    localparam int DW = (TW > CW) ? TW : CW;

    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 160;
    // a result passes the entry queue and the output register, a trailing summary follows
    localparam int SETTLE_CYCLES  = 8;
    // longest quiet spell of a healthy run is a sender gap or stall block
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BLOCKS
    } stall_style_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    logic [TW-1:0]        sample_time  = '0;
    logic signed [AW-1:0] sample_angle = '0;
    logic                 last_sample  = 1'b0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic                 kind;
    logic [TW-1:0]        peak_time;
    logic [AW-2:0]        peak_magnitude;
    logic [CW-1:0]        peak_count;
    logic [1:0]           status;
    logic                 last;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_GAP_MODE;
    logic [DW-1:0]        cfg_data     = '0;

    int fail_count;
    int outstanding;
    int peak_reports;
    int summaries;

    // sender bookkeeping
    int            samples_sent  = 0;
    int            settings_used = 0;
    int            burst_left    = 0;
    bit            valid_on      = 1'b0;
    logic [TW-1:0] now_us        = '0;

    abs_peak_detector_min_gap u_dut (.*);

    abs_peak_detector_min_gap_checker u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------

    // angles lean towards the extremes and small values, so that plateaus,
    // sign flips and the saturating negative end all turn up often
    function automatic logic signed [AW-1:0] pick_angle();
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            4, 5, 6: return AW'($urandom_range(0, 80) - 40);
            default: return AW'($urandom);
        endcase
    endfunction

    // one sample transaction; valid stays up across a burst and may drop for
    // a random gap once the burst is spent
    task automatic send_sample(input logic [TW-1:0] t,
                               input logic signed [AW-1:0] a,
                               input logic fin);
        int gap;
        sample_valid <= 1'b1;
        sample_time  <= t;
        sample_angle <= a;
        last_sample  <= fin;
        valid_on      = 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        samples_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                valid_on      = 1'b0;
                repeat (gap) @(posedge clk);
            end
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // a record of timed samples closed by last_sample; well-formed records
    // keep the time stamps mostly nondecreasing, noisy ones scatter them
    task automatic send_record(input int len, input bit noisy);
        int i;
        if ($urandom_range(0, 15) == 0)
            now_us = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
        for (i = 0; i < len; i++)
        begin
            if (noisy)
                now_us = $urandom;
            else if ($urandom_range(0, 19) == 0)
                now_us = now_us - $urandom_range(1, 500);
            else
                now_us = now_us + $urandom_range(0, 80);
            send_sample(now_us, noisy ? AW'($urandom) : pick_angle(), i == len - 1);
        end
    endtask

    // stop sending, wait until every owed result is in, then let the block
    // finish any sample still on its way that closes no peak
    task automatic settle();
        if (valid_on)
        begin
            sample_valid <= 1'b0;
            valid_on      = 1'b0;
        end
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // register side, only ever used while the block is idle
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic mode, input logic [CW-1:0] index_gap,
                                  input logic [TW-1:0] time_gap,
                                  input logic [CW-1:0] peak_floor);
        write_reg(CFG_GAP_MODE, DW'(mode));
        write_reg(CFG_MIN_INDEX_GAP, DW'(index_gap));
        write_reg(CFG_MIN_TIME_GAP, DW'(time_gap));
        write_reg(CFG_MIN_PEAK_COUNT, DW'(peak_floor));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // result side: back-pressure in spells of differing character
    // ------------------------------------------------------------------
    initial
    begin : result_backpressure
        stall_style_t style;
        int           span;
        int           i;
        forever
        begin
            style = stall_style_t'($urandom_range(0, 3));
            span  = $urandom_range(20, 200);
            for (i = 0; i < span; i++)
            begin
                @(posedge clk);
                case (style)
                    STALL_NONE:  result_stall <= 1'b0;
                    STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
                    default:     result_stall <= ((i / 6) % 2) == 1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run once nothing has moved for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int            p;
        int            count;
        int            len;
        int            pick;
        logic          mode;
        logic [CW-1:0] index_gap;
        logic [TW-1:0] time_gap;
        logic [CW-1:0] peak_floor;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a one-sample and a two-sample record, both too short
        send_sample(32'd10, 24'h7FFFFF, 1'b1);
        send_sample(32'd20, AW'(-100), 1'b0);
        send_sample(32'd30, AW'(200), 1'b1);
        // most negative angle as a peak, a plateau that is no peak, and a
        // peak that only the final sample can close
        send_sample(32'd100, AW'(100), 1'b0);
        send_sample(32'd110, 24'h800000, 1'b0);
        send_sample(32'd120, AW'(50), 1'b0);
        send_sample(32'd130, 24'h7FFFFF, 1'b0);
        send_sample(32'd140, 24'h7FFFFF, 1'b0);
        send_sample(32'd150, AW'(10), 1'b1);
        settle();

        // time gap with a step back in time, rejected, then a peak at the
        // top of the time range
        apply_settings(GAP_MODE_TIME, '1, 32'd100, '0);
        send_sample(32'd1000, AW'(0), 1'b0);
        send_sample(32'd1010, AW'(9), 1'b0);
        send_sample(32'd1020, AW'(0), 1'b0);
        send_sample(32'd900, AW'(9), 1'b0);
        send_sample(32'd900, AW'(0), 1'b0);
        send_sample(32'hFFFF_FFFF, AW'(9), 1'b0);
        send_sample(32'hFFFF_FFFF, AW'(0), 1'b1);
        settle();

        // zero time gap lets peaks through even as time runs backwards
        apply_settings(GAP_MODE_TIME, '0, '0, 20'd2);
        send_sample(32'd50, AW'(1), 1'b0);
        send_sample(32'd40, AW'(5), 1'b0);
        send_sample(32'd30, AW'(1), 1'b0);
        send_sample(32'd20, AW'(5), 1'b0);
        send_sample(32'd10, AW'(1), 1'b0);
        send_sample(32'd0, AW'(5), 1'b1);
        settle();

        // random records under a fresh setting per phase; the first ones
        // pin the registers at their extremes
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: apply_settings(GAP_MODE_COUNT, '1, '1, '1);
                1: apply_settings(GAP_MODE_TIME, '0, '0, '0);
                2: apply_settings(GAP_MODE_TIME, '0, '1, '0);
                default:
                begin
                    mode = 1'($urandom_range(0, 1));
                    pick = $urandom_range(0, 3);
                    index_gap = (pick == 0) ? CW'(0) : (pick == 1) ? CW'(1) :
                                (pick == 2) ? CW'($urandom_range(2, 10)) : CW'($urandom);
                    pick = $urandom_range(0, 3);
                    time_gap = (pick == 0) ? TW'(0) : (pick == 1) ? TW'($urandom_range(1, 100)) :
                               (pick == 2) ? TW'($urandom_range(100, 2000)) : TW'($urandom);
                    pick = $urandom_range(0, 2);
                    peak_floor = (pick == 0) ? CW'(0) : (pick == 1) ? CW'($urandom_range(1, 6)) :
                                 CW'($urandom);
                    apply_settings(mode, index_gap, time_gap, peak_floor);
                end
            endcase
            count = 0;
            while (count < PHASE_SAMPLES)
            begin
                pick = $urandom_range(0, 19);
                len  = (pick == 0) ? 1 : (pick == 1) ? 2 :
                       (pick == 2) ? $urandom_range(60, 120) : $urandom_range(3, 30);
                send_record(len, $urandom_range(0, 7) == 0);
                count += len;
            end
            settle();
        end

        $display("covered %0d samples under %0d register settings", samples_sent,
                 settings_used + 1);
        $display("checked %0d peak reports and %0d record summaries, %0d mismatches",
                 peak_reports, summaries, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
